[hdl/modexp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// shared constants and types of the modular exponentiation core
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int LIMBS     = 8;
  localparam int LIMB_W    = 32;
  localparam int NUM_W     = LIMBS * LIMB_W;
  localparam int BIT_CNT_W = $clog2(NUM_W);
  localparam int LIMB_CNT_W = $clog2(LIMBS);
  localparam int IDX_W     = 3;

  typedef logic [NUM_W-1:0] num_t;

  typedef enum logic [1:0] {
    ACT_LOAD_BASE = 2'd0,
    ACT_LOAD_EXP  = 2'd1,
    ACT_LOAD_MOD  = 2'd2,
    ACT_START     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DBL,
    ST_ADD,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_SQR,
    PH_MULB
  } phase_e;

endpackage
`default_nettype wire

[hdl/modular_exponentiation_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// multiprecision base^exponent mod modulus, binary square-and-multiply
// ----------------------------------------------------------------------------
// usage:
//   input words with action 0, 1, 2 load one 32-bit limb of base, exponent
//   or modulus. a start word runs the exponentiation and then emits LIMBS
//   result words, least significant limb first, with last on the top limb
//   and error set (limbs zero) for a zero modulus.
// timing:
//   every modular product is shift-and-add over 256 multiplier bits on one
//   shared 256-bit add/compare/subtract unit: a doubling per multiplier bit,
//   an addition per set multiplier bit, then a finishing step.
//   a start does one base reduction plus 256 squarings and one multiply per
//   set exponent bit, then emits one result word per cycle while out_stall_i
//   is low.
//   in_stall_o is high from the start word until the last result word is
//   taken; while out_stall_i is high the core holds the current result word.
// reset:
//   rst_ni clears the limb stores to zero and returns the core to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
  import modexp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [IDX_W-1:0]  limb_index_i,
  input  wire logic [LIMB_W-1:0] limb_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IDX_W-1:0]       out_index_o,
  output logic [LIMB_W-1:0]      out_value_o,
  output logic                   last_o,
  output logic                   error_o
);

  logic [LIMBS-1:0][LIMB_W-1:0] base_q, exp_q, mod_q;
  num_t acc_q, acc_d, b_q, b_d, r_q, r_d, ma_q, ma_d, mb_q, mb_d, e_q, e_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d, ecnt_q, ecnt_d;
  logic [LIMB_CNT_W-1:0] ocnt_q, ocnt_d;
  logic err_q, err_d;
  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  num_t mod_n, one_n, y, add_res;
  logic [NUM_W:0] sum;
  logic in_acc, out_acc, mod_zero, mod_one;

  assign mod_n    = num_t'(mod_q);
  assign mod_zero = (mod_n == '0);
  assign mod_one  = (mod_n == num_t'(1));
  assign one_n    = mod_one ? '0 : num_t'(1);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_index_o = IDX_W'(ocnt_q);
  assign out_value_o = acc_q[ocnt_q*LIMB_W +: LIMB_W];
  assign last_o      = (ocnt_q == LIMB_CNT_W'(LIMBS-1));
  assign error_o     = err_q;

  // shared modular adder
  assign y       = (state_q == ST_ADD) ? mb_q : r_q;
  assign sum     = {1'b0, r_q} + {1'b0, y};
  assign add_res = (sum >= {1'b0, mod_n}) ? NUM_W'(sum - {1'b0, mod_n}) : sum[NUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      exp_q   <= '0;
      mod_q   <= '0;
      state_q <= ST_IDLE;
      phase_q <= PH_PRE;
      cnt_q   <= '0;
      ecnt_q  <= '0;
      ocnt_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      if (in_acc && (32'(limb_index_i) < LIMBS)) begin
        unique case (action_e'(action_i))
          ACT_LOAD_BASE: base_q[limb_index_i[LIMB_CNT_W-1:0]] <= limb_value_i;
          ACT_LOAD_EXP:  exp_q[limb_index_i[LIMB_CNT_W-1:0]]  <= limb_value_i;
          ACT_LOAD_MOD:  mod_q[limb_index_i[LIMB_CNT_W-1:0]]  <= limb_value_i;
          ACT_START: ;
          default: ;
        endcase
      end
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ecnt_q  <= ecnt_d;
      ocnt_q  <= ocnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    r_q   <= r_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    e_q   <= e_d;
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ecnt_d  = ecnt_q;
    ocnt_d  = ocnt_q;
    err_d   = err_q;
    acc_d   = acc_q;
    b_d     = b_q;
    r_d     = r_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    e_d     = e_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_e'(action_i) == ACT_START)) begin
          ocnt_d = '0;
          if (mod_zero) begin
            err_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_OUT;
          end else begin
            err_d   = 1'b0;
            acc_d   = one_n;
            e_d     = num_t'(exp_q);
            ecnt_d  = BIT_CNT_W'(NUM_W-1);
            ma_d    = num_t'(base_q);
            mb_d    = one_n;
            r_d     = '0;
            cnt_d   = BIT_CNT_W'(NUM_W-1);
            phase_d = PH_PRE;
            state_d = ST_DBL;
          end
        end
      end
      ST_DBL, ST_ADD: begin
        r_d = add_res;
        if (state_q == ST_DBL && ma_q[NUM_W-1]) begin
          state_d = ST_ADD;
        end else if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          ma_d    = {ma_q[NUM_W-2:0], 1'b0};
          state_d = ST_DBL;
        end
      end
      ST_DONE: begin
        cnt_d   = BIT_CNT_W'(NUM_W-1);
        state_d = ST_DBL;
        if (phase_q == PH_PRE) begin
          b_d     = r_q;
          ma_d    = acc_q;
          mb_d    = acc_q;
          phase_d = PH_SQR;
        end else if (phase_q == PH_SQR && e_q[NUM_W-1]) begin
          acc_d   = r_q;
          ma_d    = r_q;
          mb_d    = b_q;
          phase_d = PH_MULB;
        end else begin
          acc_d = r_q;
          if (ecnt_q == '0) begin
            state_d = ST_OUT;
          end else begin
            ecnt_d  = ecnt_q - 1'b1;
            e_d     = {e_q[NUM_W-2:0], 1'b0};
            ma_d    = r_q;
            mb_d    = r_q;
            phase_d = PH_SQR;
          end
        end
        r_d = (state_d == ST_DBL) ? '0 : r_q;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_o) begin
            state_d = ST_IDLE;
          end else begin
            ocnt_d = ocnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> out_value_o == '0)
    else $error("error word with nonzero limb");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while idle");

  a_last_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_o |=> state_q == ST_IDLE)
    else $error("no return to idle after last word");

  a_r_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (r_q < mod_n))
    else $error("product not reduced");

endmodule
`default_nettype wire
